### rtl/core/baro_temp_compensated_height_unit_assert.svh
// Assertion macros used by the sequencer of the barometric height unit.
`ifndef BARO_TEMP_COMPENSATED_HEIGHT_UNIT_ASSERT_SVH
`define BARO_TEMP_COMPENSATED_HEIGHT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BTCH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BTCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTCH_ASSERT_SAME(lbl, ante, cons)
`define BTCH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/btch_pkg.sv
// Package with constants, types and the thermistor table of the height unit.
package btch_pkg;

  localparam int PROFILE_DEPTH = 200;
  localparam int PROFILE_AW    = $clog2(PROFILE_DEPTH);
  localparam int TABLE_ENTRIES = 32;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_ZERO   = 2'd3;

  localparam logic REG_HEIGHT_SCALE = 1'b0;
  localparam logic REG_TILT_LIMIT   = 1'b1;

  localparam logic signed [31:0] HEIGHT_SCALE_RST = 32'sd65536;
  localparam logic [14:0]        TILT_LIMIT_RST   = 15'd6434;

  localparam logic [11:0]        ADC_LOW      = 12'd128;
  localparam logic [11:0]        ADC_HIGH     = 12'd3968;
  localparam logic signed [16:0] TEMP_DEFAULT = 17'sd6400;
  localparam logic signed [26:0] TEMP_MIN     = -27'sd12800;
  localparam logic signed [26:0] TEMP_MAX     = 27'sd37888;
  localparam logic signed [8:0]  K_OFFSET     = 9'sd50;
  localparam logic [12:0]        BLEND_GAIN   = 13'd6554;

  typedef enum logic [4:0] {
    S_IDLE, S_TEMP, S_CMD, S_CMDW, S_RK, S_RK1, S_MA, S_MB, S_CP,
    S_HM0, S_HM1, S_HF, S_CALS, S_CALB, S_BK0, S_BK1, S_BJ0, S_BJ1,
    S_TILT, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TEMP, OP_CMD, OP_CMDW, OP_RK, OP_RK1, OP_MA, OP_MB,
    OP_CP, OP_HM0, OP_HM1, OP_HF, OP_CALS, OP_CALB, OP_BK0, OP_BK1, OP_BJ0,
    OP_BJ1, OP_TILT, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic sample_ok;
    logic active;
  } dp_stat_t;

  function automatic logic signed [16:0] temp_lut(input logic [4:0] i);
    logic signed [16:0] v;
    unique case (i)
      5'd0:  v = -17'sd25600;
      5'd1:  v = -17'sd8278;
      5'd2:  v = -17'sd5665;
      5'd3:  v = -17'sd3973;
      5'd4:  v = -17'sd2673;
      5'd5:  v = -17'sd1589;
      5'd6:  v = -17'sd643;
      5'd7:  v = 17'sd211;
      5'd8:  v = 17'sd999;
      5'd9:  v = 17'sd1739;
      5'd10: v = 17'sd2445;
      5'd11: v = 17'sd3127;
      5'd12: v = 17'sd3791;
      5'd13: v = 17'sd4445;
      5'd14: v = 17'sd5095;
      5'd15: v = 17'sd5746;
      5'd16: v = 17'sd6403;
      5'd17: v = 17'sd7071;
      5'd18: v = 17'sd7757;
      5'd19: v = 17'sd8466;
      5'd20: v = 17'sd9206;
      5'd21: v = 17'sd9987;
      5'd22: v = 17'sd10819;
      5'd23: v = 17'sd11716;
      5'd24: v = 17'sd12700;
      5'd25: v = 17'sd13796;
      5'd26: v = 17'sd15047;
      5'd27: v = 17'sd16517;
      5'd28: v = 17'sd18318;
      5'd29: v = 17'sd20667;
      5'd30: v = 17'sd24076;
      5'd31: v = 17'sd30325;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/btch_in_if.sv
// Input channel carrying one sample or command beat.
interface btch_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [11:0]        thermistor_adc;
  logic [23:0]        pressure_word;
  logic               start_calibration;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic [7:0]         entry_index;
  logic signed [31:0] write_value;

  modport source (output valid, cmd, thermistor_adc, pressure_word, start_calibration,
                  roll_angle, pitch_angle, entry_index, write_value, input ready);
  modport sink (input valid, cmd, thermistor_adc, pressure_word, start_calibration,
                roll_angle, pitch_angle, entry_index, write_value, output ready);
endinterface

### rtl/core/btch_out_if.sv
// Output channel carrying one result beat.
interface btch_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] temperature;
  logic signed [31:0] compensated_pressure;
  logic signed [31:0] height;
  logic               valid_res;
  logic               calibrating;
  logic               calibration_done;
  logic signed [31:0] read_value;

  modport source (output valid, temperature, compensated_pressure, height, valid_res,
                  calibrating, calibration_done, read_value, input ready);
  modport sink (input valid, temperature, compensated_pressure, height, valid_res,
                calibrating, calibration_done, read_value, output ready);
endinterface

### rtl/core/baro_temp_compensated_height_unit.sv
// Commands and overflow words take a shorter path than samples, and samples while
// calibrating a longer one. Items are handled one at a time: a new beat is taken
// only once the sequencer is idle again, after the last result has gone into the
// output register; the sequencer and its single shared multiplier set this.
// A finished result waits in the output register until the receiver takes it.
// Reset (synchronous, active high) clears the profile valid bits, the zero
// reference, the flags and the configuration to their defaults at once.
module baro_temp_compensated_height_unit (
  input  logic        clk,
  input  logic        rst,
  btch_in_if.sink     in_ch,
  btch_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  btch_pkg::dp_ctl_t  ctl;
  btch_pkg::dp_stat_t stat;

  btch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  btch_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .stat                (stat),
    .cmd                 (in_ch.cmd),
    .thermistor_adc      (in_ch.thermistor_adc),
    .pressure_word       (in_ch.pressure_word),
    .start_calibration   (in_ch.start_calibration),
    .roll_angle          (in_ch.roll_angle),
    .pitch_angle         (in_ch.pitch_angle),
    .entry_index         (in_ch.entry_index),
    .write_value         (in_ch.write_value),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .temperature         (out_ch.temperature),
    .compensated_pressure(out_ch.compensated_pressure),
    .height              (out_ch.height),
    .valid_res           (out_ch.valid_res),
    .calibrating         (out_ch.calibrating),
    .calibration_done    (out_ch.calibration_done),
    .read_value          (out_ch.read_value)
  );
endmodule

### rtl/core/btch_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/btch_ctrl.sv
// Sequencer that steps the datapath through one item at a time.
`include "baro_temp_compensated_height_unit_assert.svh"
module btch_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  btch_pkg::dp_stat_t stat,
  output btch_pkg::dp_ctl_t  ctl
);
  btch_pkg::state_t state, state_next;
  logic ov, ov_next;
  logic load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btch_pkg::S_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  assign in_ready  = (state == btch_pkg::S_IDLE);
  assign out_valid = ov;

  always_comb begin
    state_next = state;
    ctl.op     = btch_pkg::OP_NONE;
    load       = 1'b0;
    unique case (state)
      btch_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.op     = btch_pkg::OP_LOAD;
          state_next = btch_pkg::S_TEMP;
        end
      end
      btch_pkg::S_TEMP: begin
        ctl.op     = btch_pkg::OP_TEMP;
        state_next = btch_pkg::S_CMD;
      end
      btch_pkg::S_CMD: begin
        // The temperature is registered now, so a sample can address its profile neighbors.
        if (stat.sample_ok) begin
          ctl.op     = btch_pkg::OP_RK;
          state_next = btch_pkg::S_RK1;
        end else begin
          ctl.op     = btch_pkg::OP_CMD;
          state_next = btch_pkg::S_CMDW;
        end
      end
      btch_pkg::S_CMDW: begin
        ctl.op     = btch_pkg::OP_CMDW;
        state_next = btch_pkg::S_HM0;
      end
      btch_pkg::S_RK: begin
        ctl.op     = btch_pkg::OP_RK;
        state_next = btch_pkg::S_RK1;
      end
      btch_pkg::S_RK1: begin
        ctl.op     = btch_pkg::OP_RK1;
        state_next = btch_pkg::S_MA;
      end
      btch_pkg::S_MA: begin
        ctl.op     = btch_pkg::OP_MA;
        state_next = btch_pkg::S_MB;
      end
      btch_pkg::S_MB: begin
        ctl.op     = btch_pkg::OP_MB;
        state_next = btch_pkg::S_CP;
      end
      btch_pkg::S_CP: begin
        ctl.op     = btch_pkg::OP_CP;
        state_next = btch_pkg::S_HM0;
      end
      btch_pkg::S_HM0: begin
        ctl.op     = btch_pkg::OP_HM0;
        state_next = btch_pkg::S_HM1;
      end
      btch_pkg::S_HM1: begin
        ctl.op     = btch_pkg::OP_HM1;
        state_next = btch_pkg::S_HF;
      end
      btch_pkg::S_HF: begin
        ctl.op     = btch_pkg::OP_HF;
        state_next = stat.sample_ok ? btch_pkg::S_CALS : btch_pkg::S_FIN;
      end
      btch_pkg::S_CALS: begin
        ctl.op     = btch_pkg::OP_CALS;
        state_next = btch_pkg::S_CALB;
      end
      btch_pkg::S_CALB: begin
        ctl.op     = btch_pkg::OP_CALB;
        state_next = stat.active ? btch_pkg::S_BK0 : btch_pkg::S_FIN;
      end
      btch_pkg::S_BK0: begin
        ctl.op     = btch_pkg::OP_BK0;
        state_next = btch_pkg::S_BK1;
      end
      btch_pkg::S_BK1: begin
        ctl.op     = btch_pkg::OP_BK1;
        state_next = btch_pkg::S_BJ0;
      end
      btch_pkg::S_BJ0: begin
        ctl.op     = btch_pkg::OP_BJ0;
        state_next = btch_pkg::S_BJ1;
      end
      btch_pkg::S_BJ1: begin
        ctl.op     = btch_pkg::OP_BJ1;
        state_next = btch_pkg::S_TILT;
      end
      btch_pkg::S_TILT: begin
        ctl.op     = btch_pkg::OP_TILT;
        state_next = btch_pkg::S_FIN;
      end
      btch_pkg::S_FIN: begin
        if (!ov || out_ready) begin
          ctl.op     = btch_pkg::OP_FIN;
          load       = 1'b1;
          state_next = btch_pkg::S_IDLE;
        end
      end
      default: state_next = btch_pkg::S_IDLE;
    endcase
  end

  assign ov_next = (ov && !out_ready) || load;

  `BTCH_ASSERT_NEXT(a_accept_to_temp, in_valid && in_ready, state == btch_pkg::S_TEMP)
  `BTCH_ASSERT_NEXT(a_fin_holds, state == btch_pkg::S_FIN && ov && !out_ready,
                    state == btch_pkg::S_FIN)
  `BTCH_ASSERT_SAME(a_calb_after_cals, state == btch_pkg::S_CALB,
                    $past(state) == btch_pkg::S_CALS)
endmodule

### rtl/core/btch_dp.sv
// Datapath: temperature table, profile memory, shared multiplier and result registers.
module btch_dp (
  input  logic               clk,
  input  logic               rst,
  input  btch_pkg::dp_ctl_t  ctl,
  output btch_pkg::dp_stat_t stat,
  input  logic [1:0]         cmd,
  input  logic [11:0]        thermistor_adc,
  input  logic [23:0]        pressure_word,
  input  logic               start_calibration,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] write_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [16:0] temperature,
  output logic signed [31:0] compensated_pressure,
  output logic signed [31:0] height,
  output logic               valid_res,
  output logic               calibrating,
  output logic               calibration_done,
  output logic signed [31:0] read_value
);
  localparam int AW = btch_pkg::PROFILE_AW;
  localparam logic [8:0] DEPTH9 = 9'(btch_pkg::PROFILE_DEPTH);

  function automatic logic [21:0] BLEND_W(input logic [8:0] w);
    return 22'(btch_pkg::BLEND_GAIN) * 22'(w);
  endfunction

  logic [1:0]         cmd_r;
  logic [11:0]        adc_r;
  logic [23:0]        pw_r;
  logic               start_r;
  logic signed [15:0] roll_r, pitch_r;
  logic [7:0]         idx_r;
  logic signed [31:0] wval_r;

  logic signed [31:0] hs;
  logic [14:0]        tilt;
  logic signed [31:0] zero_ref, last_comp;
  logic               active, dvalid;
  logic [btch_pkg::PROFILE_DEPTH-1:0] pvalid;

  logic signed [16:0] temp_r;
  logic signed [31:0] pk, pk1, bval, rd_r, height_r;
  logic signed [65:0] acc;
  logic signed [57:0] mul_p;
  logic [22:0]        wk, wk1;
  logic               done_r;

  // Temperature interpolation.
  logic [4:0]         ti;
  logic [6:0]         tf;
  logic signed [17:0] tdiff;
  logic signed [26:0] tsum;
  logic signed [16:0] temp_calc;

  always_comb begin
    ti    = adc_r[11:7];
    tf    = adc_r[6:0];
    tdiff = 18'(btch_pkg::temp_lut(5'(ti + 5'd1))) - 18'(btch_pkg::temp_lut(ti));
    tsum  = 27'(btch_pkg::temp_lut(ti)) + 27'((27'(tdiff) * $signed({20'd0, tf})) >>> 7);
    if (adc_r <= btch_pkg::ADC_LOW || adc_r >= btch_pkg::ADC_HIGH) begin
      temp_calc = btch_pkg::TEMP_DEFAULT;
    end else if (tsum < btch_pkg::TEMP_MIN) begin
      temp_calc = btch_pkg::TEMP_MIN[16:0];
    end else if (tsum > btch_pkg::TEMP_MAX) begin
      temp_calc = btch_pkg::TEMP_MAX[16:0];
    end else begin
      temp_calc = tsum[16:0];
    end
  end

  // Profile neighbors of the current temperature.
  logic [7:0]         q;
  logic [8:0]         ksum;
  logic [7:0]         k;
  logic [8:0]         k1;
  logic               k_ok, k1_ok, idx_ok;
  logic signed [29:0] cnt;

  assign q      = temp_r[7:0];
  assign ksum   = 9'(temp_r[16:8] + btch_pkg::K_OFFSET);
  assign k      = ksum[7:0];
  assign k1     = {1'b0, k} + 9'd1;
  assign k_ok   = ({1'b0, k} < DEPTH9);
  assign k1_ok  = (k1 < DEPTH9);
  assign idx_ok = ({1'b0, idx_r} < DEPTH9);
  assign cnt    = $signed({1'b0, pw_r[20:0], 8'd0});

  assign stat.sample_ok = (cmd_r == btch_pkg::CMD_SAMPLE) && (pw_r[23:22] == 2'b00);
  assign stat.active    = active;

  // Memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic          rd_ok, rvalid_q;
  logic signed [31:0] rdata_eff;

  logic signed [32:0] diff;
  logic signed [33:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [32:0] blend_d;
  logic signed [65:0] blend_sum;

  always_comb begin
    ram_raddr = AW'(idx_r);
    rd_ok     = idx_ok;
    unique case (ctl.op)
      btch_pkg::OP_RK: begin
        ram_raddr = AW'(k);
        rd_ok     = k_ok;
      end
      btch_pkg::OP_RK1: begin
        ram_raddr = AW'(k1);
        rd_ok     = k1_ok;
      end
      default: begin
        ram_raddr = AW'(idx_r);
        rd_ok     = idx_ok;
      end
    endcase
  end

  assign rdata_eff = rvalid_q ? $signed(ram_rdata) : 32'sd0;
  assign diff      = 33'(zero_ref) - 33'(last_comp);
  assign blend_sum = 66'(mul_p >>> 24) +
                     66'((ctl.op == btch_pkg::OP_BJ1) ? pk1 : pk);

  always_comb begin
    mul_a   = 34'sd0;
    mul_b   = 24'sd0;
    blend_d = 33'sd0;
    unique case (ctl.op)
      btch_pkg::OP_MA: begin
        mul_a = 34'(pk);
        mul_b = $signed(24'(9'd256 - {1'b0, q}));
      end
      btch_pkg::OP_MB: begin
        mul_a = 34'(pk1);
        mul_b = $signed({16'd0, q});
      end
      btch_pkg::OP_HM0: begin
        mul_a = 34'(diff);
        mul_b = $signed({8'd0, hs[15:0]});
      end
      btch_pkg::OP_HM1: begin
        mul_a = 34'(diff);
        mul_b = 24'($signed(hs[31:16]));
      end
      btch_pkg::OP_BK0: begin
        blend_d = 33'(bval) - 33'(pk);
        mul_a   = 34'(blend_d);
        mul_b   = $signed({1'b0, wk});
      end
      btch_pkg::OP_BJ0: begin
        blend_d = 33'(bval) - 33'(pk1);
        mul_a   = 34'(blend_d);
        mul_b   = $signed({1'b0, wk1});
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 24'sd0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_r);
    ram_wdata = wval_r;
    unique case (ctl.op)
      btch_pkg::OP_CMD: begin
        ram_we = (cmd_r == btch_pkg::CMD_WRITE) && idx_ok;
      end
      btch_pkg::OP_BK1: begin
        ram_we    = k_ok;
        ram_waddr = AW'(k);
        ram_wdata = (pk == 32'sd0) ? bval : btch_pkg::sat32(blend_sum);
      end
      btch_pkg::OP_BJ1: begin
        ram_we    = k1_ok;
        ram_waddr = AW'(k1);
        ram_wdata = (pk1 == 32'sd0) ? bval : btch_pkg::sat32(blend_sum);
      end
      default: ram_we = 1'b0;
    endcase
  end

  btch_ram #(
    .WIDTH(32),
    .DEPTH(btch_pkg::PROFILE_DEPTH)
  ) u_profile (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state: configuration, zero reference, flags and entry valid bits.
  logic signed [59:0] off;
  logic signed [65:0] htotal;
  logic signed [16:0] roll_x, pitch_x, lim_x;

  assign off     = (60'(mul_p) + 60'(acc)) >>> 8;
  assign htotal  = (66'(mul_p) <<< 16) + acc;
  assign roll_x  = 17'(roll_r);
  assign pitch_x = 17'(pitch_r);
  assign lim_x   = $signed({2'b00, tilt});

  always_ff @(posedge clk) begin
    if (rst) begin
      hs        <= btch_pkg::HEIGHT_SCALE_RST;
      tilt      <= btch_pkg::TILT_LIMIT_RST;
      zero_ref  <= 32'sd0;
      last_comp <= 32'sd0;
      active    <= 1'b0;
      dvalid    <= 1'b0;
      pvalid    <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= rd_ok && pvalid[ram_raddr];
      if (ram_we) begin
        pvalid[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          btch_pkg::REG_HEIGHT_SCALE: hs   <= $signed(cfg_data);
          btch_pkg::REG_TILT_LIMIT:   tilt <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (ctl.op)
        btch_pkg::OP_CMD: begin
          if (cmd_r == btch_pkg::CMD_SAMPLE) dvalid <= 1'b0;
          if (cmd_r == btch_pkg::CMD_ZERO) zero_ref <= wval_r;
        end
        btch_pkg::OP_CP: begin
          last_comp <= btch_pkg::sat32(66'(cnt) - 66'(off));
          dvalid    <= 1'b1;
        end
        btch_pkg::OP_CALS: begin
          if (start_r && !active) begin
            active   <= 1'b1;
            zero_ref <= 32'(cnt);
          end
        end
        btch_pkg::OP_TILT: begin
          if (roll_x > lim_x || roll_x < -lim_x || pitch_x > lim_x || pitch_x < -lim_x) begin
            active <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (ctl.op)
      btch_pkg::OP_LOAD: begin
        cmd_r   <= cmd;
        adc_r   <= thermistor_adc;
        pw_r    <= pressure_word;
        start_r <= start_calibration;
        roll_r  <= roll_angle;
        pitch_r <= pitch_angle;
        idx_r   <= entry_index;
        wval_r  <= write_value;
        done_r  <= 1'b0;
        rd_r    <= 32'sd0;
      end
      btch_pkg::OP_TEMP: temp_r <= temp_calc;
      btch_pkg::OP_CMDW: begin
        if (cmd_r == btch_pkg::CMD_READ) rd_r <= rdata_eff;
      end
      btch_pkg::OP_RK1:  pk  <= rdata_eff;
      btch_pkg::OP_MA:   pk1 <= rdata_eff;
      btch_pkg::OP_MB:   acc <= 66'(mul_p);
      btch_pkg::OP_HM0:  acc <= 66'sd0;
      btch_pkg::OP_HM1:  acc <= 66'(mul_p);
      btch_pkg::OP_HF:   height_r <= btch_pkg::sat32(htotal >>> 8);
      btch_pkg::OP_CALS: begin
        wk  <= 23'(BLEND_W(9'd256 - {1'b0, q}));
        wk1 <= 23'(BLEND_W({1'b0, q}));
      end
      btch_pkg::OP_CALB: bval <= btch_pkg::sat32(66'(cnt) - 66'(zero_ref));
      btch_pkg::OP_TILT: begin
        if (roll_x > lim_x || roll_x < -lim_x || pitch_x > lim_x || pitch_x < -lim_x) begin
          done_r <= 1'b1;
        end
      end
      btch_pkg::OP_FIN: begin
        temperature          <= temp_r;
        compensated_pressure <= last_comp;
        height               <= height_r;
        valid_res            <= dvalid;
        calibrating          <= active;
        calibration_done     <= done_r;
        read_value           <= rd_r;
      end
      default: ;
    endcase
  end
endmodule

### bench/btch_tb_pkg.sv
`timescale 1ns / 1ps
// Types shared by the height unit testbench.
package btch_tb_pkg;
  import btch_pkg::*;

  typedef struct {
    logic [1:0]         cmd;
    logic [11:0]        adc;
    logic [23:0]        pw;
    logic               start;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic [7:0]         idx;
    logic signed [31:0] wval;
  } baro_item_t;

  typedef struct {
    logic signed [16:0] temperature;
    logic signed [31:0] comp;
    logic signed [31:0] height;
    logic               valid_res;
    logic               calibrating;
    logic               done;
    logic signed [31:0] read_value;
  } baro_result_t;
endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the barometric height unit: directed and random beats checked against a predictor.
module tb_top;
  import btch_pkg::*;
  import btch_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  btch_in_if  in_ch ();
  btch_out_if out_ch ();

  baro_temp_compensated_height_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state.
  longint            prof [PROFILE_DEPTH];
  longint            zero_ref, last_comp, scale, tilt;
  bit                cal_active, dvalid;
  longint            tbl [TABLE_ENTRIES];

  baro_item_t   pending_items [$];
  baro_result_t expected_results [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           hold_off = 1'b0;
  bit           stim_done = 1'b0;

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lookup_temp(logic [11:0] adc);
    longint t;
    int i, f;
    if (adc <= 128 || adc >= 3968) return 25 * 256;
    i = adc >> 7;
    f = adc & 127;
    t = tbl[i] + floor_div((tbl[i + 1] - tbl[i]) * f, 7);
    if (t < -50 * 256) t = -50 * 256;
    if (t > 148 * 256) t = 148 * 256;
    return t;
  endfunction

  function automatic longint profile_at(longint e);
    if (e < 0 || e >= PROFILE_DEPTH) return 0;
    return prof[e];
  endfunction

  function automatic void blend_entry(longint e, longint b, longint w);
    if (e < 0 || e >= PROFILE_DEPTH) return;
    if (prof[e] == 0) prof[e] = b;
    else prof[e] = clamp32(prof[e] + floor_div((b - prof[e]) * 6554 * w, 24));
  endfunction

  function automatic longint height_of(longint comp);
    longint diff, hi, lo;
    diff = zero_ref - comp;
    hi = floor_div(scale, 16);
    lo = scale - hi * 65536;
    return clamp32(diff * hi * 256 + floor_div(diff * lo, 8));
  endfunction

  function automatic baro_result_t predict_height(baro_item_t it);
    baro_result_t r;
    longint temp, tf, q, k, off, cnt, lim, rl, pt;
    temp = lookup_temp(it.adc);
    r.read_value = 0;
    r.done = 1'b0;
    if (it.cmd == CMD_SAMPLE && (it.pw & 24'hC00000) == 0) begin
      tf = floor_div(temp, 8);
      q = temp - tf * 256;
      k = tf + 50;
      off = floor_div(profile_at(k) * (256 - q) + profile_at(k + 1) * q, 8);
      cnt = longint'(it.pw & 24'h1FFFFF) * 256;
      last_comp = clamp32(cnt - off);
      r.height = height_of(last_comp);
      dvalid = 1'b1;
      if (it.start && !cal_active) begin
        cal_active = 1'b1;
        zero_ref = cnt;
      end
      if (cal_active) begin
        lim = tilt;
        rl = it.roll;
        pt = it.pitch;
        blend_entry(k, clamp32(cnt - zero_ref), 256 - q);
        blend_entry(k + 1, clamp32(cnt - zero_ref), q);
        if (rl > lim || rl < -lim || pt > lim || pt < -lim) begin
          cal_active = 1'b0;
          r.done = 1'b1;
        end
      end
    end else begin
      case (it.cmd)
        CMD_SAMPLE: dvalid = 1'b0;
        CMD_WRITE:  if (it.idx < PROFILE_DEPTH) prof[it.idx] = it.wval;
        CMD_READ:   r.read_value = profile_at(it.idx);
        default:    zero_ref = it.wval;
      endcase
      r.height = height_of(last_comp);
    end
    r.temperature = temp;
    r.comp = last_comp;
    r.valid_res = dvalid;
    r.calibrating = cal_active;
    return r;
  endfunction

  function automatic baro_item_t rand_item(int kind);
    baro_item_t it;
    it.cmd = $urandom_range(0, 3);
    it.adc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(129, 3967);
    it.pw = $urandom & 24'h3FFFFF;
    if ($urandom_range(0, 15) == 0) it.pw = $urandom;
    it.start = ($urandom_range(0, 7) == 0);
    it.roll = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000;
    it.pitch = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000;
    it.idx = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, PROFILE_DEPTH - 1);
    it.wval = $urandom;
    if (kind == 0) begin
      it.cmd = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : CMD_SAMPLE;
    end
    return it;
  endfunction

  function automatic baro_item_t make_item(logic [1:0] c, logic [11:0] a, logic [23:0] p,
                                           logic s, logic [15:0] ro, logic [15:0] pi,
                                           logic [7:0] ix, logic [31:0] w);
    baro_item_t it;
    it.cmd = c; it.adc = a; it.pw = p; it.start = s;
    it.roll = ro; it.pitch = pi; it.idx = ix; it.wval = w;
    return it;
  endfunction

  // Driver: bursts with random gaps.
  int burst_left = 0, gap_left = 0;
  baro_item_t cur;
  bit beat_taken = 1'b0;

  // Remembers whether the beat on the bus was taken at the last rising edge.
  always @(posedge clk) begin
    beat_taken <= in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.thermistor_adc <= '0;
      in_ch.pressure_word <= '0;
      in_ch.start_calibration <= 1'b0;
      in_ch.roll_angle <= '0;
      in_ch.pitch_angle <= '0;
      in_ch.entry_index <= '0;
      in_ch.write_value <= '0;
    end else if (!in_ch.valid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cur.cmd;
        in_ch.thermistor_adc <= cur.adc;
        in_ch.pressure_word <= cur.pw;
        in_ch.start_calibration <= cur.start;
        in_ch.roll_angle <= cur.roll;
        in_ch.pitch_angle <= cur.pitch;
        in_ch.entry_index <= cur.idx;
        in_ch.write_value <= cur.wval;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern; a requested hold-off is counted here.
  int stall_phase = 0;
  int hold_count = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'b11) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict on accepted inputs, compare on accepted results.
  baro_result_t exp_r;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_height(make_item(in_ch.cmd,
          in_ch.thermistor_adc, in_ch.pressure_word, in_ch.start_calibration,
          in_ch.roll_angle, in_ch.pitch_angle, in_ch.entry_index, in_ch.write_value)));
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result beat");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.temperature !== exp_r.temperature ||
              out_ch.compensated_pressure !== exp_r.comp ||
              out_ch.height !== exp_r.height ||
              out_ch.valid_res !== exp_r.valid_res ||
              out_ch.calibrating !== exp_r.calibrating ||
              out_ch.calibration_done !== exp_r.done ||
              out_ch.read_value !== exp_r.read_value) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"mismatch exp t=%0d p=%0d h=%0d v=%b c=%b d=%b r=%0d",
                        " got t=%0d p=%0d h=%0d v=%b c=%b d=%b r=%0d"},
                exp_r.temperature, exp_r.comp, exp_r.height, exp_r.valid_res,
                exp_r.calibrating, exp_r.done, exp_r.read_value,
                out_ch.temperature, out_ch.compensated_pressure, out_ch.height,
                out_ch.valid_res, out_ch.calibrating, out_ch.calibration_done,
                out_ch.read_value);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEIGHT_SCALE) scale = longint'($signed(val));
    else tilt = val & 32'h7FFF;
  endtask

  task automatic drain_beats();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) pending_items.push_back(rand_item(0));
      else pending_items.push_back(rand_item(1));
    end
  endtask

  initial begin
    int scales [6];
    int tilts [6];
    tbl = '{-25600, -8278, -5665, -3973, -2673, -1589, -643, 211,
            999, 1739, 2445, 3127, 3791, 4445, 5095, 5746,
            6403, 7071, 7757, 8466, 9206, 9987, 10819, 11716,
            12700, 13796, 15047, 16517, 18318, 20667, 24076, 30325};
    foreach (prof[i]) prof[i] = 0;
    zero_ref = 0; last_comp = 0; cal_active = 0; dvalid = 0;
    scale = 65536; tilt = 6434;
    scales = '{65536, 32'h7FFFFFFF, 32'h80000000, -65536, 12345, 0};
    tilts = '{6434, 32767, 0, 1000, 3000, 20000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats: field extremes, every command, overflow, calibration.
    pending_items.push_back(make_item(CMD_SAMPLE, 0, 24'h000000, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 128, 24'h3FFFFF, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 129, 24'h200000, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 3967, 24'h1FFFFF, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 3968, 24'hFFFFFF, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 4095, 24'h400000, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 2000, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
    pending_items.push_back(make_item(CMD_WRITE, 2000, 0, 0, 0, 0, 199, 32'h80000000));
    pending_items.push_back(make_item(CMD_WRITE, 2000, 0, 0, 0, 0, 255, 32'h1234));
    pending_items.push_back(make_item(CMD_READ, 2000, 0, 0, 0, 0, 199, 0));
    pending_items.push_back(make_item(CMD_READ, 2000, 0, 0, 0, 0, 255, 0));
    pending_items.push_back(make_item(CMD_READ, 2000, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_ZERO, 2000, 0, 0, 0, 0, 0, 32'h80000000));
    pending_items.push_back(make_item(CMD_SAMPLE, 200, 24'h0FFFFF, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 1500, 24'h0FF000, 1, 100, -100, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 1500, 24'hC00000, 0, 16'h7FFF, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 1600, 24'h0FE000, 0, 16'h7FFF, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 1600, 24'h0FE000, 1, 0, 16'h8000, 0, 0));
    pending_items.push_back(make_item(CMD_SAMPLE, 1600, 24'h0FE000, 0, 16'h8000, 0, 0, 0));
    pending_items.push_back(make_item(CMD_ZERO, 2000, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
    pending_items.push_back(make_item(CMD_SAMPLE, 3000, 24'h000001, 0, 0, 0, 0, 0));
    drain_beats();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_HEIGHT_SCALE, scales[ph]);
      write_reg(REG_TILT_LIMIT, tilts[ph]);
      random_phase(220);
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering beats.
        hold_off = 1'b1;
        wait (hold_count == HOLD_CYCLES);
        hold_off = 1'b0;
      end
      drain_beats();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
